>>> rtl/core/mrdf_pkg.sv
// Shared types, constants and codes for the mesh relay duplicate filter.
package mrdf_pkg;

    // Cache geometry.
    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);

    // Field widths.
    localparam int ADDR_W  = 48;
    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 32;

    // Configuration port.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_HOPS  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPIRY_MS = CFG_INDEX_W'(1);

    localparam logic [BYTE_W-1:0] MAX_HOPS_RESET  = BYTE_W'(3);
    localparam logic [TIME_W-1:0] EXPIRY_MS_RESET = TIME_W'(8000);

    // Result codes.
    typedef enum logic [1:0] {
        VERDICT_FORWARD   = 2'd0,
        VERDICT_HOP_LIMIT = 2'd1,
        VERDICT_DUPLICATE = 2'd2
    } t_verdict;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT
    } t_state;

    // One received fragment header.
    typedef struct packed {
        logic [ADDR_W-1:0] origin_addr;
        logic [BYTE_W-1:0] message_id;
        logic [BYTE_W-1:0] fragment_index;
        logic [BYTE_W-1:0] hops_so_far;
        logic [TIME_W-1:0] time_ms;
    } t_in_item;

    // One relay decision.
    typedef struct packed {
        t_verdict          verdict;
        logic [BYTE_W-1:0] next_hops;
    } t_out_item;

    // One cache entry as held in the RAM.
    typedef struct packed {
        logic [ADDR_W-1:0] origin;
        logic [BYTE_W-1:0] message;
        logic [BYTE_W-1:0] fragment;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Status from the compare unit to the sequencer.
    typedef struct packed {
        logic expired;
        logic key_match;
    } t_cmp_res;

endpackage

>>> rtl/core/mrdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mrdf_cmp.sv
// Shared entry compare unit: wrapping age check and key equality.
module mrdf_cmp (
    input  mrdf_pkg::t_entry                 i_entry,
    input  mrdf_pkg::t_entry                 i_key,
    input  logic [mrdf_pkg::TIME_W-1:0]      i_expiry_ms,
    output mrdf_pkg::t_cmp_res               o_res
);
    import mrdf_pkg::*;

    logic [TIME_W-1:0] age;

    // The age wraps modulo 2^32, so a plain subtract of the stamp is enough.
    assign age = i_key.stamp - i_entry.stamp;

    assign o_res.expired   = (age > i_expiry_ms);
    assign o_res.key_match = (i_entry.message  == i_key.message)  &&
                             (i_entry.fragment == i_key.fragment) &&
                             (i_entry.origin   == i_key.origin);

endmodule

>>> rtl/core/mesh_relay_duplicate_filter_core.sv
// Top level of the mesh relay duplicate filter: scan sequencer, valid bits and registers.
//
//  Channel   Direction  Handshake                    Payload
//  item      in         start, busy                  i_item (t_in_item)
//  result    out        o_res_strobe, one cycle      o_res (t_out_item)
//  config    in         i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
//  A fragment at or above the hop limit gives its result in the cycle after the transfer.
//  Otherwise one entry is checked per cycle through the single RAM read port and the
//  shared compare unit: a duplicate result is registered from the scan state, and a
//  miss goes through every entry and then the insert state, which registers the result.
//  Synchronous reset clears the valid bits and the insert pointer and resets the config registers.
//  The result strobe cannot be held off; configuration is always ready.
module mesh_relay_duplicate_filter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mrdf_pkg::t_in_item                i_item,
    output logic                              o_res_strobe,
    output mrdf_pkg::t_out_item               o_res,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mrdf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mrdf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mrdf_pkg::*;

    t_state                   r_state, n_state;
    t_entry                   r_key, n_key;
    logic [BYTE_W-1:0]        r_hops, n_hops;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [IDX_W-1:0]         r_ptr, n_ptr;
    logic [CACHE_ENTRIES-1:0] r_valid, n_valid;
    logic [BYTE_W-1:0]        r_max_hops, n_max_hops;
    logic [TIME_W-1:0]        r_expiry, n_expiry;
    logic                     r_res_strobe, n_res_strobe;
    t_out_item                r_res, n_res;

    logic                     accept;
    logic                     hop_drop;
    logic                     last_idx;
    logic                     entry_live;
    logic                     kill;
    logic                     dup;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_raddr;
    t_entry                   ram_rdata;
    t_cmp_res                 cmp_res;

    assign accept   = start && (r_state == ST_IDLE);
    assign hop_drop = (i_item.hops_so_far >= r_max_hops);
    assign last_idx = (r_idx == IDX_W'(CACHE_ENTRIES - 1));

    // Entry store; the read address runs one entry ahead of the compare.
    always_comb begin
        ram_raddr = '0;
        if (r_state == ST_SCAN && !last_idx) begin
            ram_raddr = r_idx + IDX_W'(1);
        end
    end

    assign ram_we = (r_state == ST_INSERT);

    mrdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata (r_key),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared compare unit, used once per scanned entry.
    mrdf_cmp u_cmp (
        .i_entry     (ram_rdata),
        .i_key       (r_key),
        .i_expiry_ms (r_expiry),
        .o_res       (cmp_res)
    );

    // An expired entry is dropped before its key is considered.
    assign entry_live = r_valid[r_idx];
    assign kill       = entry_live && cmp_res.expired;
    assign dup        = entry_live && !cmp_res.expired && cmp_res.key_match;

    // Next state of the scan sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !hop_drop) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (dup) begin
                    n_state = ST_IDLE;
                end else if (last_idx) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and result updates for each state.
    always_comb begin
        n_key        = r_key;
        n_hops       = r_hops;
        n_idx        = r_idx;
        n_ptr        = r_ptr;
        n_valid      = r_valid;
        n_res_strobe = 1'b0;
        n_res        = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_key.origin   = i_item.origin_addr;
                    n_key.message  = i_item.message_id;
                    n_key.fragment = i_item.fragment_index;
                    n_key.stamp    = i_item.time_ms;
                    n_hops         = i_item.hops_so_far;
                    n_idx          = '0;
                    if (hop_drop) begin
                        n_res_strobe    = 1'b1;
                        n_res.verdict   = VERDICT_HOP_LIMIT;
                        n_res.next_hops = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (kill) begin
                    n_valid[r_idx] = 1'b0;
                end
                if (dup) begin
                    n_res_strobe    = 1'b1;
                    n_res.verdict   = VERDICT_DUPLICATE;
                    n_res.next_hops = '0;
                end else if (!last_idx) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_INSERT: begin
                n_valid[r_ptr] = 1'b1;
                if (r_ptr == IDX_W'(CACHE_ENTRIES - 1)) begin
                    n_ptr = '0;
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
                n_res_strobe    = 1'b1;
                n_res.verdict   = VERDICT_FORWARD;
                n_res.next_hops = r_hops + BYTE_W'(1);
            end
            default: begin
                n_res_strobe = 1'b0;
            end
        endcase
    end

    // Register writes; an unknown index is ignored.
    always_comb begin
        n_max_hops = r_max_hops;
        n_expiry   = r_expiry;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_HOPS:  n_max_hops = i_cfg_data[BYTE_W-1:0];
                CFG_EXPIRY_MS: n_expiry   = i_cfg_data[TIME_W-1:0];
                default: begin
                    n_max_hops = r_max_hops;
                end
            endcase
        end
    end

    // Control state and registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_ptr        <= '0;
            r_valid      <= '0;
            r_max_hops   <= MAX_HOPS_RESET;
            r_expiry     <= EXPIRY_MS_RESET;
            r_res_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_ptr        <= n_ptr;
            r_valid      <= n_valid;
            r_max_hops   <= n_max_hops;
            r_expiry     <= n_expiry;
            r_res_strobe <= n_res_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_hops <= n_hops;
        r_res  <= n_res;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;
    assign o_cfg_ready  = 1'b1;

endmodule

>>> rtl/core/mrdf_checker.sv
// Port-level checker for the mesh relay duplicate filter, bound to the top level.
module mrdf_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_res_strobe,
    input mrdf_pkg::t_out_item  o_res
);
    import mrdf_pkg::*;

    // A transfer either starts a scan or gives a hop-limit result at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || (o_res_strobe && o_res.verdict == VERDICT_HOP_LIMIT)))
        else $error("transfer neither started a scan nor gave a hop-limit result");

    // Every scan ends with a result in the cycle in which busy falls.
    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_res_strobe)
        else $error("scan ended without a result");

    // No result shows while a scan is still running.
    a_no_result_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> !o_res_strobe)
        else $error("result shown in the middle of a scan");

    // Dropped fragments carry no hop count; forwarded ones carry a non-zero one.
    a_hops_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> ((o_res.verdict == VERDICT_FORWARD && o_res.next_hops != '0) ||
                          (o_res.verdict == VERDICT_HOP_LIMIT && o_res.next_hops == '0) ||
                          (o_res.verdict == VERDICT_DUPLICATE && o_res.next_hops == '0)))
        else $error("verdict and hop count disagree");

endmodule

bind mesh_relay_duplicate_filter_core mrdf_checker u_mrdf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_strobe (o_res_strobe),
    .o_res        (o_res)
);
